/* src/kcct_pkg.sv */
package kcct_pkg;

    // item kinds on the input side
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_POLL = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // controller phases
    localparam logic [1:0] PH_ENTRY = 2'd0;
    localparam logic [1:0] PH_ARMED = 2'd1;
    localparam logic [1:0] PH_HEAT  = 2'd2;

    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 6;
    localparam int COUNT_W    = 3;

    // digit positions, most significant first
    localparam int POS_HT = 0;
    localparam int POS_HU = 1;
    localparam int POS_MT = 2;
    localparam int POS_MU = 3;
    localparam int POS_ST = 4;
    localparam int POS_SU = 5;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [NUM_DIGITS-1:0] digits_t;

    // commands to the countdown unit
    typedef struct packed {
        logic load;
        logic dec;
        logic clear;
    } cnt_cmd_t;

endpackage

/* src/kcct_count.sv */
module kcct_count (
    input  logic               clk,
    input  logic               rst_n,
    input  kcct_pkg::cnt_cmd_t cmd,
    input  kcct_pkg::digits_t  load_digits,  // raw entry digits, may be unnormalized
    output kcct_pkg::digits_t  count,        // normalized count, hour tens 0..10
    output kcct_pkg::digits_t  count_dec,    // count minus one second
    output logic               zero,
    output logic               dec_zero
);
    import kcct_pkg::*;

    digits_t count_reg;
    digits_t count_next;
    digits_t norm;
    logic    c_s;
    logic    c_mu;
    logic    c_m;
    logic    c_hu;
    digit_t  mu_sum;
    digit_t  mt_sum;
    digit_t  hu_sum;
    logic    b_su;
    logic    b_st;
    logic    b_mu;
    logic    b_mt;
    logic    b_hu;

    // fold entered digits into hours / minutes below 60 / seconds below 60
    always_comb
    begin
        c_s          = (load_digits[POS_ST] >= 4'd6);
        norm[POS_SU] = load_digits[POS_SU];
        norm[POS_ST] = c_s ? load_digits[POS_ST] - 4'd6 : load_digits[POS_ST];

        mu_sum       = load_digits[POS_MU] + {3'd0, c_s};
        c_mu         = (mu_sum == 4'd10);
        norm[POS_MU] = c_mu ? 4'd0 : mu_sum;
        mt_sum       = load_digits[POS_MT] + {3'd0, c_mu};
        c_m          = (mt_sum >= 4'd6);
        norm[POS_MT] = c_m ? mt_sum - 4'd6 : mt_sum;

        hu_sum       = load_digits[POS_HU] + {3'd0, c_m};
        c_hu         = (hu_sum == 4'd10);
        norm[POS_HU] = c_hu ? 4'd0 : hu_sum;
        norm[POS_HT] = load_digits[POS_HT] + {3'd0, c_hu};
    end

    // mixed-radix decrement with borrow chain
    always_comb
    begin
        b_su = (count_reg[POS_SU] == 4'd0);
        b_st = b_su && (count_reg[POS_ST] == 4'd0);
        b_mu = b_st && (count_reg[POS_MU] == 4'd0);
        b_mt = b_mu && (count_reg[POS_MT] == 4'd0);
        b_hu = b_mt && (count_reg[POS_HU] == 4'd0);

        count_dec[POS_SU] = b_su ? 4'd9 : count_reg[POS_SU] - 4'd1;
        count_dec[POS_ST] = !b_su ? count_reg[POS_ST] :
                            (b_st ? 4'd5 : count_reg[POS_ST] - 4'd1);
        count_dec[POS_MU] = !b_st ? count_reg[POS_MU] :
                            (b_mu ? 4'd9 : count_reg[POS_MU] - 4'd1);
        count_dec[POS_MT] = !b_mu ? count_reg[POS_MT] :
                            (b_mt ? 4'd5 : count_reg[POS_MT] - 4'd1);
        count_dec[POS_HU] = !b_mt ? count_reg[POS_HU] :
                            (b_hu ? 4'd9 : count_reg[POS_HU] - 4'd1);
        count_dec[POS_HT] = !b_hu ? count_reg[POS_HT] : count_reg[POS_HT] - 4'd1;
    end

    assign zero     = (count_reg == '0);
    assign dec_zero = (count_dec == '0);
    assign count    = count_reg;

    // count register update, clear wins
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.load)
        begin
            count_next = norm;
        end
        else if (cmd.dec)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* src/keypad_countdown_cook_timer_core.sv */
// Cook timer controller with an HH:MM:SS countdown.
// Input beats arrive on s_tvalid/s_tready: s_tuser carries the kind of event
// (keypad digit, switch poll, one-second tick), s_tdata the digit and the
// switch states. Six digits entered most significant first arm the block; a
// poll with door, weight and start begins heating if the count is nonzero,
// each tick counts one second down, stop aborts. Every input beat yields
// exactly one result beat on m_tvalid/m_tready carrying the phase, digit
// count, six shown digits, the drive flag and the time-ended / user-stopped
// pulses. The beat passes an input register and a result register with the
// controller logic between them. Throughput: one beat per cycle while the
// receiver keeps m_tready high; the countdown is kept in normalized digit
// form so a tick is a short borrow chain and needs no division.
// When the receiver stalls the result register holds its beat and the input
// register holds the next one; s_tready drops only when both are full.
// Reset (rst_n low, asynchronous) returns to the entry phase with all digits,
// the digit count and the countdown cleared and both channels empty.
module keypad_countdown_cook_timer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_digit[3:0], door_closed, weight_present,
                                   // start_pressed, stop_pressed
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // phase[1:0], entered_digits[2:0], hour_tens,
                                   // hour_units, minute_tens, minute_units,
                                   // second_tens, second_units (4 bits each),
                                   // drive_on, time_ended, user_stopped
);
    import kcct_pkg::*;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [1:0]         in_mode_reg;
    logic [7:0]         in_data_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        out_data_reg;
    logic [31:0]        out_data_next;

    // controller state
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [COUNT_W-1:0] digit_count_reg;
    logic [COUNT_W-1:0] digit_count_next;
    digits_t            store_reg;
    digits_t            store_next;

    logic               adv;
    logic               s_beat;
    digit_t             key;
    logic               door;
    logic               weight;
    logic               start;
    logic               stop;
    digits_t            store_key;
    digits_t            shown;
    digits_t            count;
    digits_t            count_dec;
    logic               count_zero;
    logic               dec_zero;
    cnt_cmd_t           cmd;
    cnt_cmd_t           cmd_gated;
    logic               back;
    logic               ended;
    logic               stopped;

    // handshake and pipeline advance
    assign adv            = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || adv;
    assign s_beat         = s_tvalid && s_tready;
    assign in_valid_next  = s_beat || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !m_tready);
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;

    // unpack the held beat
    assign key    = (in_data_reg[3:0] > DIGIT_MAX) ? DIGIT_MAX : in_data_reg[3:0];
    assign door   = in_data_reg[4];
    assign weight = in_data_reg[5];
    assign start  = in_data_reg[6];
    assign stop   = in_data_reg[7];

    // entry store with the new key dropped into place
    always_comb
    begin
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            store_key[j] = (COUNT_W'(j) == digit_count_reg) ? key : store_reg[j];
        end
    end

    // shown digits after a tick, hour tens saturates at nine
    always_comb
    begin
        shown         = count_dec;
        shown[POS_HT] = (count_dec[POS_HT] > DIGIT_MAX) ? DIGIT_MAX : count_dec[POS_HT];
    end

    kcct_count u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_gated),
        .load_digits (store_key),
        .count       (count),
        .count_dec   (count_dec),
        .zero        (count_zero),
        .dec_zero    (dec_zero)
    );

    // controller next state for the held beat
    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        store_next       = store_reg;
        cmd              = '0;
        back             = 1'b0;
        ended            = 1'b0;
        stopped          = 1'b0;

        case (phase_reg)
            PH_ENTRY:
            begin
                if (in_mode_reg == MODE_KEY)
                begin
                    store_next = store_key;
                    if (digit_count_reg == COUNT_W'(NUM_DIGITS - 1))
                    begin
                        cmd.load         = 1'b1;
                        digit_count_next = '0;
                        phase_next       = PH_ARMED;
                    end
                    else
                    begin
                        digit_count_next = digit_count_reg + 1'b1;
                    end
                end
            end
            PH_ARMED:
            begin
                if (in_mode_reg == MODE_POLL)
                begin
                    if (stop)
                    begin
                        back    = 1'b1;
                        stopped = 1'b1;
                    end
                    else if (door && weight && start)
                    begin
                        if (count_zero)
                        begin
                            back  = 1'b1;
                            ended = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HEAT;
                        end
                    end
                end
            end
            PH_HEAT:
            begin
                if (in_mode_reg == MODE_POLL)
                begin
                    if (stop)
                    begin
                        back    = 1'b1;
                        stopped = 1'b1;
                    end
                end
                else if (in_mode_reg == MODE_TICK)
                begin
                    if (count_zero || dec_zero)
                    begin
                        back  = 1'b1;
                        ended = 1'b1;
                    end
                    else
                    begin
                        cmd.dec    = 1'b1;
                        store_next = shown;
                    end
                end
            end
            default:
            begin
                back = 1'b1;
            end
        endcase

        // return to entry clears everything
        if (back)
        begin
            phase_next       = PH_ENTRY;
            digit_count_next = '0;
            store_next       = '0;
            cmd.clear        = 1'b1;
        end
    end

    assign cmd_gated = adv ? cmd : '0;

    // result beat
    assign out_data_next = {stopped, ended, (phase_next == PH_HEAT),
                            store_next[POS_SU], store_next[POS_ST],
                            store_next[POS_MU], store_next[POS_MT],
                            store_next[POS_HU], store_next[POS_HT],
                            digit_count_next, phase_next};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_ENTRY;
            digit_count_reg <= '0;
            store_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                phase_reg       <= phase_next;
                digit_count_reg <= digit_count_next;
                store_reg       <= store_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // digits are only counted while entering time
    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_count_reg != '0) |-> (phase_reg == PH_ENTRY))
        else $error("digit count nonzero outside entry");

    // heating never holds an exhausted countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEAT) |-> !count_zero)
        else $error("heating with zero count");

    // an end or abort always lands back in entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (ended || stopped)) |=> (phase_reg == PH_ENTRY) && (count == '0))
        else $error("end of run did not return to entry");

    // the two pulses never fire together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[30] && m_tdata[31]))
        else $error("time ended and stop in one beat");

endmodule
